>>> src/lqe_pkg.sv
package lqe_pkg;

  // Table size default; the neighbour field reaches 256 entries at most
  localparam int NEIGHBOURS_DEF = 256;
  localparam int NB_REACH       = 256;

  // Field widths
  localparam int OP_W        = 2;
  localparam int NB_W        = 8;
  localparam int SINR_W      = 16;
  localparam int FRAMES_W    = 32;
  localparam int RATIO_W     = 17;
  localparam int QUAL_W      = 7;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 8;

  // Divider geometry
  localparam int DIV_W       = 33;
  localparam int STEP_W      = 5;
  localparam int SCALED_W    = 24;

  // Op codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SINR_FLOOR   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SINR_CEILING = 4'd1;

  localparam logic [SINR_W-1:0] SINR_FLOOR_RST   = 16'd0;
  localparam logic [SINR_W-1:0] SINR_CEILING_RST = 16'd5120;
  localparam logic [SINR_W-1:0] SINR_LOWEST      = 16'h8000;
  localparam logic [SINR_W:0]   THREE_DB         = 17'd768;
  localparam logic [QUAL_W-1:0] QUAL_FULL        = 7'd100;
  localparam logic [7:0]        PERCENT          = 8'd100;

  localparam logic [STEP_W-1:0] STEPS_RATIO = 5'd17;
  localparam logic [STEP_W-1:0] STEPS_QUAL  = 5'd7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RATIO,
    ST_QPREP,
    ST_QSCALE,
    ST_QCHECK,
    ST_QDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [SINR_W-1:0]  sinr;
    logic [RATIO_W-1:0] ratio;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [NB_W-1:0] addr;
    entry_t          data;
  } tbl_wr_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   rem_init;
    logic [DIV_W-1:0]   divisor;
    logic [RATIO_W-1:0] stream;
    logic [STEP_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> src/lqe_table.sv
module lqe_table #(
  parameter int DEPTH = lqe_pkg::NB_REACH
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [lqe_pkg::NB_W-1:0]    rd_addr,
  output lqe_pkg::entry_t             rd_data,
  input  lqe_pkg::tbl_wr_t            wr
);

  localparam int ADDR_W = $clog2(DEPTH);

  lqe_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

>>> src/lqe_div.sv
// Restoring divider, one quotient bit per cycle. Dividend bits shift in
// MSB first from stream; remainder must start below the divisor.
module lqe_div (
  input  logic              clk,
  input  logic              rst,
  input  lqe_pkg::div_req_t req,
  output lqe_pkg::div_rsp_t rsp
);

  logic [lqe_pkg::DIV_W-1:0]   rem;
  logic [lqe_pkg::DIV_W-1:0]   divisor;
  logic [lqe_pkg::RATIO_W-1:0] stream;
  logic [lqe_pkg::RATIO_W-1:0] quot;
  logic [lqe_pkg::STEP_W-1:0]  steps_left;
  logic                        busy;
  logic                        done;

  logic [lqe_pkg::DIV_W:0]     rem_sh;
  logic [lqe_pkg::DIV_W:0]     rem_sub;
  logic                        fits;

  assign rem_sh  = {rem, stream[lqe_pkg::RATIO_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy       <= 1'b1;
        steps_left <= req.steps;
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == lqe_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      divisor <= req.divisor;
      stream  <= req.stream;
      quot    <= '0;
    end else if (busy) begin
      rem    <= fits ? rem_sub[lqe_pkg::DIV_W-1:0] : rem_sh[lqe_pkg::DIV_W-1:0];
      stream <= {stream[lqe_pkg::RATIO_W-2:0], 1'b0};
      quot   <= {quot[lqe_pkg::RATIO_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> src/link_quality_estimator_unit.sv
// Channel  Dir  Handshake          Beat
// s_       in   s_tvalid/s_tready  op, neighbour, sinr_avg, rx_frames, missed_frames
// m_       out  m_tvalid/m_tready  quality, known
// cfg_     in   cfg_valid/cfg_ready cfg_index selects sinr_floor / sinr_ceiling
//
// One item in flight. Add, remove, spare op or unknown neighbour: lookup, done. Report
// with zero frames: lookup, qprep, qscale, qcheck, qdiv if needed, done; with frames a
// ratio divide comes between lookup and qprep. Both divides run on the shared serial
// divider (17 steps ratio, 7 quality). Next beat is taken the cycle after the result
// is loaded. After reset a clearing pass wipes all min(NEIGHBOURS,256) entries with
// s_tready low. A stalled m_ side holds the block in its final state; config always taken.
module link_quality_estimator_unit #(
  parameter int NEIGHBOURS = lqe_pkg::NEIGHBOURS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // op[1:0], neighbour[9:2], sinr_avg[25:10], rx_frames[57:26],
  // missed_frames[89:58], zero fill above
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lqe_pkg::IN_TDATA_W-1:0]      s_tdata,
  // quality[6:0], known[7]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lqe_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lqe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lqe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Only the reachable part of the table is stored.
  localparam int DEPTH  = (NEIGHBOURS < lqe_pkg::NB_REACH) ? NEIGHBOURS : lqe_pkg::NB_REACH;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int SW = lqe_pkg::SINR_W;
  localparam int RW = lqe_pkg::RATIO_W;
  localparam int FW = lqe_pkg::FRAMES_W;
  localparam int QW = lqe_pkg::QUAL_W;
  localparam int DW = lqe_pkg::DIV_W;
  localparam int PW = SW + RW;             // product d * ratio
  localparam int XW = PW + 7;              // times 100
  localparam int CW = lqe_pkg::SCALED_W;   // product * 100 / 65536

  lqe_pkg::state_t state, state_next;

  // config
  logic [SW-1:0] sinr_floor;
  logic [SW-1:0] sinr_ceiling;

  // current item
  logic [lqe_pkg::OP_W-1:0] item_op;
  logic [lqe_pkg::NB_W-1:0] item_nb;
  logic [SW-1:0]            item_sinr;
  logic [FW-1:0]            item_rx;
  logic [FW-1:0]            item_missed;
  logic                     item_known;

  // working values
  logic [SW-1:0]     sinr_sel;
  logic [RW-1:0]     ratio_sel;
  logic              d_pos;
  logic              c_pos;
  logic              ratio_nz;
  logic [SW-1:0]     span;
  logic [PW-1:0]     prod;
  logic [CW-1:0]     scaled;
  logic [QW-1:0]     res_quality;
  logic [ADDR_W-1:0] clr_addr;

  // output register
  logic [QW-1:0] out_quality;
  logic          out_known;

  // table and divider
  lqe_pkg::entry_t   rd_data;
  lqe_pkg::tbl_wr_t  tbl_wr;
  lqe_pkg::div_req_t div_req;
  lqe_pkg::div_rsp_t div_rsp;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic          in_range;
  logic          entry_known;
  logic          is_report;
  logic [DW-1:0] total;
  logic          total_zero;
  logic [SW:0]   sinr_dec;
  logic [SW-1:0] sinr_fallback;
  logic [SW:0]   d_diff;
  logic [SW:0]   c_diff;
  logic [XW-1:0] prod_x100;
  logic          q_ovf;
  logic [QW-1:0] q_div;
  logic          ratio_go;
  logic          qual_go;

  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign cfg_ready = 1'b1;

  assign in_range    = 32'(item_nb) < NEIGHBOURS;
  assign entry_known = in_range & rd_data.valid;
  assign is_report   = item_op == lqe_pkg::OP_REPORT;
  assign total       = {1'b0, item_rx} + {1'b0, item_missed};
  assign total_zero  = total == '0;

  // last SINR less 3 dB, saturating at the lowest code
  assign sinr_dec      = {rd_data.sinr[SW-1], rd_data.sinr} - lqe_pkg::THREE_DB;
  assign sinr_fallback = (sinr_dec[SW] & ~sinr_dec[SW-1]) ? lqe_pkg::SINR_LOWEST
                                                          : sinr_dec[SW-1:0];

  assign d_diff    = {sinr_sel[SW-1], sinr_sel} - {sinr_floor[SW-1], sinr_floor};
  assign c_diff    = {sinr_ceiling[SW-1], sinr_ceiling} - {sinr_floor[SW-1], sinr_floor};
  assign prod_x100 = XW'(prod) * XW'(lqe_pkg::PERCENT);
  assign q_ovf     = scaled[CW-1:7] >= {1'b0, span};
  assign q_div     = div_rsp.quot[QW-1:0];

  assign ratio_go = (state == lqe_pkg::ST_LOOKUP) & is_report & entry_known & ~total_zero;
  assign qual_go  = (state == lqe_pkg::ST_QCHECK) & d_pos & c_pos & ~q_ovf;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      sinr_floor   <= lqe_pkg::SINR_FLOOR_RST;
      sinr_ceiling <= lqe_pkg::SINR_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lqe_pkg::REG_SINR_FLOOR:   sinr_floor   <= cfg_data;
        lqe_pkg::REG_SINR_CEILING: sinr_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lqe_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == lqe_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lqe_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = lqe_pkg::ST_IDLE;
      end
      lqe_pkg::ST_IDLE: begin
        if (accept) state_next = lqe_pkg::ST_LOOKUP;
      end
      lqe_pkg::ST_LOOKUP: begin
        if (is_report && entry_known) begin
          state_next = total_zero ? lqe_pkg::ST_QPREP : lqe_pkg::ST_RATIO;
        end else begin
          state_next = lqe_pkg::ST_DONE;
        end
      end
      lqe_pkg::ST_RATIO: begin
        if (div_rsp.done) state_next = lqe_pkg::ST_QPREP;
      end
      lqe_pkg::ST_QPREP:  state_next = lqe_pkg::ST_QSCALE;
      lqe_pkg::ST_QSCALE: state_next = lqe_pkg::ST_QCHECK;
      lqe_pkg::ST_QCHECK: begin
        state_next = qual_go ? lqe_pkg::ST_QDIV : lqe_pkg::ST_DONE;
      end
      lqe_pkg::ST_QDIV: begin
        if (div_rsp.done) state_next = lqe_pkg::ST_DONE;
      end
      lqe_pkg::ST_DONE: begin
        if (out_free) state_next = lqe_pkg::ST_IDLE;
      end
      default: state_next = lqe_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready    = state == lqe_pkg::ST_IDLE;
    out_load    = (state == lqe_pkg::ST_DONE) & out_free;

    tbl_wr      = '0;
    tbl_wr.addr = item_nb;
    if (state == lqe_pkg::ST_CLEAR) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = lqe_pkg::NB_W'(clr_addr);
    end else if (out_load && in_range) begin
      case (item_op)
        lqe_pkg::OP_ADD: begin
          tbl_wr.en         = 1'b1;
          tbl_wr.data.valid = 1'b1;
          tbl_wr.data.sinr  = lqe_pkg::SINR_LOWEST;
        end
        lqe_pkg::OP_REMOVE: begin
          tbl_wr.en = 1'b1;
        end
        lqe_pkg::OP_REPORT: begin
          tbl_wr.en         = item_known;
          tbl_wr.data.valid = 1'b1;
          tbl_wr.data.sinr  = sinr_sel;
          tbl_wr.data.ratio = ratio_sel;
        end
        default: ;
      endcase
    end

    // ratio: (rx << 16) / total, 17 quotient bits.
    // quality: scaled / span, top bits preloaded, 7 quotient bits.
    div_req = '0;
    if (ratio_go) begin
      div_req.start    = 1'b1;
      div_req.rem_init = DW'(item_rx[FW-1:1]);
      div_req.divisor  = total;
      div_req.stream   = {item_rx[0], (RW-1)'(0)};
      div_req.steps    = lqe_pkg::STEPS_RATIO;
    end else if (qual_go) begin
      div_req.start    = 1'b1;
      div_req.rem_init = DW'(scaled[CW-1:7]);
      div_req.divisor  = DW'(span);
      div_req.stream   = {scaled[6:0], (RW-7)'(0)};
      div_req.steps    = lqe_pkg::STEPS_QUAL;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op     <= s_tdata[1:0];
      item_nb     <= s_tdata[9:2];
      item_sinr   <= s_tdata[25:10];
      item_rx     <= s_tdata[57:26];
      item_missed <= s_tdata[89:58];
    end
    unique case (state)
      lqe_pkg::ST_LOOKUP: begin
        item_known  <= entry_known;
        res_quality <= '0;
        if (total_zero) begin
          sinr_sel  <= sinr_fallback;
          ratio_sel <= rd_data.ratio;
        end else begin
          sinr_sel  <= item_sinr;
        end
      end
      lqe_pkg::ST_RATIO: begin
        if (div_rsp.done) ratio_sel <= div_rsp.quot;
      end
      lqe_pkg::ST_QPREP: begin
        d_pos    <= ~d_diff[SW] & (d_diff != '0);
        c_pos    <= ~c_diff[SW] & (c_diff != '0);
        ratio_nz <= ratio_sel != '0;
        span     <= c_diff[SW-1:0];
        prod     <= PW'(d_diff[SW-1:0]) * PW'(ratio_sel);
      end
      lqe_pkg::ST_QSCALE: begin
        scaled <= prod_x100[XW-1:16];
      end
      lqe_pkg::ST_QCHECK: begin
        if (!d_pos) begin
          res_quality <= '0;
        end else if (!c_pos) begin
          res_quality <= ratio_nz ? lqe_pkg::QUAL_FULL : '0;
        end else if (q_ovf) begin
          res_quality <= lqe_pkg::QUAL_FULL;
        end
      end
      lqe_pkg::ST_QDIV: begin
        if (div_rsp.done) begin
          res_quality <= (q_div > lqe_pkg::QUAL_FULL) ? lqe_pkg::QUAL_FULL : q_div;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_quality <= res_quality;
      out_known   <= item_known;
    end
  end

  assign m_tdata = {out_known, out_quality};

  lqe_table #(
    .DEPTH(DEPTH)
  ) u_table (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (s_tdata[9:2]),
    .rd_data (rd_data),
    .wr      (tbl_wr)
  );

  lqe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

>>> dv/link_quality_estimator_unit_tb.sv
module link_quality_estimator_unit_tb;
  import lqe_pkg::*;

  localparam int PERIOD_HALF = 5;
  localparam int RESET_CYCLES = 8;
  // Cycles with no beat on any channel before the run is called hung.
  // Slowest item: a ratio and a quality divide plus long random stalls; the
  // clearing pass after reset wipes all 256 table entries.
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_SHOWN = 10;

  localparam int SINR_MIN = -32768;
  localparam int SINR_MAX = 32767;
  localparam int DROP_3DB = 768;
  localparam int RATIO_ONE = 65536;
  localparam int TABLE_DEPTH = 256;
  localparam int SINR_FLOOR_DEF = 0;
  localparam int SINR_CEILING_DEF = 5120;

  // Op code the block does not define; it must be ignored.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [QUAL_W-1:0] quality;
    logic              known;
  } grade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // op[1:0], neighbour[9:2], sinr_avg[25:10], rx_frames[57:26],
  // missed_frames[89:58], zero fill above
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  // quality[6:0], known[7]
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  link_quality_estimator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #PERIOD_HALF clk = 1'b1;
    #PERIOD_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Mirror of the neighbour table and the two registers.
  // Updated at the edge where a beat or a register write is taken.
  // ---------------------------------------------------------------------
  bit     nb_live [TABLE_DEPTH];
  int     nb_sinr [TABLE_DEPTH];
  int     nb_ratio[TABLE_DEPTH];
  int     floor_q = SINR_FLOOR_DEF;
  int     ceil_q  = SINR_CEILING_DEF;

  grade_t quality_due[$];   // one grade per accepted input beat, in order
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     gap_pct = 0;      // chance of the sender sitting out a cycle
  int     stall_pct = 0;    // chance of m_tready low in a cycle

  // Truncated percent of the way from floor to ceiling, scaled by ratio.
  function automatic logic [QUAL_W-1:0] link_percent(int sinr, int ratio);
    longint num;
    longint den;
    longint q;
    if (sinr <= floor_q) return '0;
    // degenerate window: any traffic at all is full quality
    if (ceil_q <= floor_q) return (ratio != 0) ? QUAL_FULL : '0;
    num = longint'(sinr - floor_q) * longint'(ratio) * 64'd100;
    den = longint'(ceil_q - floor_q) * RATIO_ONE;
    q = num / den;
    return (q > 100) ? QUAL_FULL : QUAL_W'(q);
  endfunction

  // Applies one input beat to the mirror table, returns its grade.
  function automatic grade_t grade_beat(logic [IN_TDATA_W-1:0] beat);
    logic [OP_W-1:0] op;
    int              nb;
    int              sinr_in;
    longint          rx;
    longint          missed;
    longint          total;
    int              sinr;
    int              ratio;
    grade_t          g;
    op      = beat[1:0];
    nb      = beat[9:2];
    sinr_in = $signed(beat[25:10]);
    rx      = beat[57:26];
    missed  = beat[89:58];
    g.quality = '0;
    g.known   = nb_live[nb];
    case (op)
      OP_ADD: begin
        // re-add resets the entry to the lowest SINR and no traffic
        nb_live[nb]  = 1'b1;
        nb_sinr[nb]  = SINR_MIN;
        nb_ratio[nb] = 0;
      end
      OP_REMOVE: begin
        nb_live[nb] = 1'b0;
      end
      OP_REPORT: begin
        if (g.known) begin
          total = rx + missed;    // 33-bit sum, no wrap
          if (total == 0) begin
            // silent interval: decay SINR by 3 dB, keep old ratio
            sinr = nb_sinr[nb] - DROP_3DB;
            if (sinr < SINR_MIN) sinr = SINR_MIN;
            ratio = nb_ratio[nb];
          end else begin
            sinr  = sinr_in;
            ratio = int'((rx * RATIO_ONE) / total);
          end
          g.quality    = link_percent(sinr, ratio);
          nb_sinr[nb]  = sinr;
          nb_ratio[nb] = ratio & 'h1FFFF;
        end
      end
      default: ;  // spare op: no change, known shows the valid mark
    endcase
    return g;
  endfunction

  task automatic report_fault(string what, int exp_v, int act_v);
    if (mismatches < MAX_SHOWN)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    mismatches++;
  endtask

  // Monitor: result check, input prediction, register mirror, watchdog count.
  always @(posedge clk) begin
    grade_t g;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (quality_due.size() == 0) begin
          report_fault("result beat with nothing pending, quality", -1, m_tdata[6:0]);
        end else begin
          g = quality_due.pop_front();
          if (m_tdata[6:0] !== g.quality) report_fault("quality", g.quality, m_tdata[6:0]);
          if (m_tdata[7] !== g.known) report_fault("known", g.known, m_tdata[7]);
        end
      end
      if (s_tvalid && s_tready)
        quality_due.insert(quality_due.size(), grade_beat(s_tdata));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SINR_FLOOR:   floor_q = $signed(cfg_data);
          REG_SINR_CEILING: ceil_q = $signed(cfg_data);
          default: ;
        endcase
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= stall_pct);
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Presents one input beat (after a random gap) and holds it until taken.
  task automatic send_beat(logic [OP_W-1:0] op, logic [NB_W-1:0] nb, int sinr,
                           logic [FRAMES_W-1:0] rx, logic [FRAMES_W-1:0] missed);
    @(negedge clk);
    while (int'($urandom_range(99)) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, missed, rx, sinr[15:0], nb, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every pending result; block is idle after this.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (quality_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Add / remove / spare op bookkeeping and the known flag.
  task automatic test_table_commands();
    send_beat(OP_REPORT, 8'd5, 100, 32'd10, 32'd10);  // unknown neighbour
    send_beat(OP_ADD,    8'd5, 0, 32'd0, 32'd0);
    send_beat(OP_ADD,    8'd5, 0, 32'd0, 32'd0);      // re-add of live entry
    send_beat(OP_REPORT, 8'd5, 0, 32'd0, 32'd0);      // silent, SINR saturates
    send_beat(OP_SPARE,  8'd5, 0, 32'd1, 32'd1);
    send_beat(OP_REMOVE, 8'd5, 0, 32'd0, 32'd0);
    send_beat(OP_REMOVE, 8'd5, 0, 32'd0, 32'd0);      // remove of dead entry
    send_beat(OP_SPARE,  8'd5, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();
  endtask

  // Reports at the field extremes with the reset window 0..20 dB.
  task automatic test_reports();
    send_beat(OP_ADD,    8'd255, 0, 32'd0, 32'd0);
    send_beat(OP_REPORT, 8'd255, 5120, 32'hFFFF_FFFF, 32'd0);      // ratio 1.0
    send_beat(OP_REPORT, 8'd255, SINR_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // 33-bit total
    send_beat(OP_REPORT, 8'd255, 0, 32'd0, 32'd0);                 // decay, keep ratio
    send_beat(OP_REPORT, 8'd255, 2560, 32'd1, 32'd3);
    send_beat(OP_REPORT, 8'd255, -1, 32'd0, 32'hFFFF_FFFF);        // below floor, ratio 0
    send_beat(OP_REPORT, 8'd255, -32000, 32'd5, 32'd0);
    send_beat(OP_REPORT, 8'd255, 0, 32'd0, 32'd0);                 // decay saturates
    send_beat(OP_REPORT, 8'd255, 0, 32'd0, 32'd0);
    settle();
  endtask

  // Widest window, collapsed window, inverted window.
  task automatic test_register_extremes();
    write_reg(REG_SINR_FLOOR, SINR_MIN);
    write_reg(REG_SINR_CEILING, SINR_MAX);
    send_beat(OP_REPORT, 8'd255, SINR_MAX, 32'hFFFF_FFFF, 32'd0);
    send_beat(OP_REPORT, 8'd255, -32767, 32'd1, 32'd0);
    settle();
    write_reg(REG_SINR_FLOOR, 1000);
    write_reg(REG_SINR_CEILING, 1000);
    send_beat(OP_REPORT, 8'd255, 1001, 32'd1, 32'hFFFF_FFFF);      // ratio rounds to 0
    send_beat(OP_REPORT, 8'd255, 1001, 32'd7, 32'd1);
    settle();
    write_reg(REG_SINR_FLOOR, SINR_MAX);
    write_reg(REG_SINR_CEILING, SINR_MIN);
    send_beat(OP_REPORT, 8'd255, SINR_MAX, 32'd1, 32'd0);          // never above floor
    settle();
  endtask

  // Mostly reports to a small pool of live neighbours, with adds keeping the
  // pool populated, some removes, spare ops and full-range indexes as noise.
  task automatic test_random_phase(int gap, int stall, int floor_v, int ceil_v, int count);
    int                  sent;
    int                  span;
    int                  sinr;
    int                  pick;
    logic [OP_W-1:0]     op;
    logic [NB_W-1:0]     nb;
    logic [FRAMES_W-1:0] rx;
    logic [FRAMES_W-1:0] missed;
    settle();
    write_reg(REG_SINR_FLOOR, floor_v);
    write_reg(REG_SINR_CEILING, ceil_v);
    gap_pct   = gap;
    stall_pct = stall;
    span = (ceil_v > floor_v) ? ceil_v - floor_v : floor_v - ceil_v;
    span += 1024;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8)       op = OP_ADD;
      else if (pick < 13) op = OP_REMOVE;
      else if (pick < 17) op = OP_SPARE;
      else                op = OP_REPORT;
      nb = ($urandom_range(9) < 8) ? NB_W'($urandom_range(15)) : NB_W'($urandom);
      // SINR mostly around the current window, sometimes anywhere
      if ($urandom_range(3) == 0) begin
        sinr = $signed(16'($urandom));
      end else begin
        sinr = floor_v - 512 + int'($urandom_range(span));
        if (sinr > SINR_MAX) sinr = SINR_MAX;
        if (sinr < SINR_MIN) sinr = SINR_MIN;
      end
      case ($urandom_range(9))
        0, 1: begin rx = '0;       missed = '0;       end
        2:    begin rx = $urandom; missed = $urandom; end
        3:    begin rx = '0;       missed = $urandom; end
        4:    begin rx = $urandom; missed = '0;       end
        default: begin
          rx     = $urandom_range(1000);
          missed = $urandom_range(1000);
        end
      endcase
      send_beat(op, nb, sinr, rx, missed);
      if (op != OP_SPARE) sent++;
    end
    settle();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int fl;
    int cl;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_commands();
    test_reports();
    test_register_extremes();

    // reset window, no idling
    test_random_phase(0, 0, SINR_FLOOR_DEF, SINR_CEILING_DEF, 500);
    // ordinary random window, sender gaps
    fl = int'($urandom_range(10000)) - 8000;
    cl = fl + int'($urandom_range(12000));
    test_random_phase(49, 0, fl, cl, 500);
    // any register values, inverted windows included, receiver stalls
    fl = $signed(16'($urandom));
    cl = $signed(16'($urandom));
    test_random_phase(0, 49, fl, cl, 500);
    // widest window, both sides idling
    test_random_phase(13, 13, SINR_MIN, SINR_MAX, 500);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && quality_due.size() == 0)
      $display("link_quality_estimator_unit_tb: clean");
    else
      $display("link_quality_estimator_unit_tb: errors");
    $finish;
  end

  // Hang detector: no beat on any channel for too long.
  initial begin
    do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("link_quality_estimator_unit_tb: errors");
    $finish;
  end

endmodule
